// File: rtl/psiq_pkg.sv
// Shared types, constants and rank compare for the priority sorted insert queue.
package psiq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int COUNT_W  = 5;
	localparam int ORDER_W  = 16;

	localparam logic [1:0] ACT_INSERT  = 2'd0;
	localparam logic [1:0] ACT_READOUT = 2'd1;
	localparam logic [1:0] ACT_CLEAR   = 2'd2;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_DROPPED  = 2'd1;
	localparam logic [1:0] ST_ENTRY    = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic               hybrid;
		logic               new_fleet;
		logic [ORDER_W-1:0] order_number;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic rotate;
	} cell_ctl_t;

	// class: 2 hybrid, 1 new fleet only, 0 other
	function automatic logic [1:0] entry_class(entry_t e);
		logic [1:0] c;
		if (e.hybrid) begin
			c = 2'd2;
		end else if (e.new_fleet) begin
			c = 2'd1;
		end else begin
			c = 2'd0;
		end
		return c;
	endfunction

	// a outranks or ties b
	function automatic logic goes_before(entry_t a, entry_t b);
		logic [1:0] ca;
		logic [1:0] cb;
		logic       r;
		ca = entry_class(a);
		cb = entry_class(b);
		if (ca != cb) begin
			r = (ca > cb);
		end else begin
			r = (a.order_number <= b.order_number);
		end
		return r;
	endfunction

endpackage

// File: rtl/psiq_cell.sv
// One slot of the sorted row: holds an entry, shifts right on insert, left on readout.
module psiq_cell
	import psiq_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  entry_t    new_entry,
	input  entry_t    left_entry,
	input  entry_t    right_entry,
	input  entry_t    head_entry,
	input  logic      left_flag,
	input  logic      occupied,
	input  logic      is_tail,
	output entry_t    entry,
	output logic      flag
);

	entry_t slot_q;

	assign entry = slot_q;
	assign flag  = !occupied || goes_before(new_entry, slot_q);

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (left_flag) begin
				slot_q <= left_entry;
			end else if (flag) begin
				slot_q <= new_entry;
			end
		end else if (ctl.rotate) begin
			slot_q <= is_tail ? head_entry : right_entry;
		end
	end

endmodule

// File: rtl/priority_sorted_insert_queue.sv
// Top level of the priority sorted insert queue: cell row, command decode and result register.
//
// An insert, a clear, a dropped insert or a readout of an empty queue gives its result with strobe
// in the cycle after the command is taken; a new command may be given at once. A readout of N
// stored entries holds busy high while the cell row rotates by one slot a cycle, streaming the
// head entry each cycle; the row is back in order when the last item leaves.
// Results are shown for exactly one cycle and cannot be held off.
module priority_sorted_insert_queue
	import psiq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic               is_hybrid,
	input  logic               is_new_fleet,
	input  logic [ORDER_W-1:0] order_number,
	output logic               strobe,
	output logic [1:0]         status,
	output logic [COUNT_W-1:0] count,
	output logic               entry_valid,
	output logic               entry_hybrid,
	output logic               entry_new_fleet,
	output logic [ORDER_W-1:0] entry_order_number,
	output logic               last
);

	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             rd_active_q;
	logic             strobe_q;
	logic [1:0]       status_q;
	logic [CNT_W-1:0] res_cnt_q;
	logic             last_q;
	entry_t           res_entry_q;
	logic             res_valid_q;

	entry_t    new_entry;
	cell_ctl_t ctl;
	logic      accept;
	logic      full;
	logic      rd_last;
	entry_t    slots [CAPACITY];
	logic      flags [CAPACITY];

	assign accept    = start && !rd_active_q;
	assign busy      = rd_active_q;
	assign full      = (cnt_q >= CNT_W'(CAPACITY));
	assign rd_last   = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == cnt_q);
	assign new_entry = '{hybrid: is_hybrid, new_fleet: is_new_fleet, order_number: order_number};

	assign ctl.insert = accept && (action == ACT_INSERT) && !full;
	assign ctl.rotate = rd_active_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_f;
		if (i == 0) begin : g_first
			assign left_e = new_entry;
			assign left_f = 1'b0;
		end else begin : g_mid
			assign left_e = slots[i-1];
			assign left_f = flags[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_e = slots[0];
		end else begin : g_inner
			assign right_e = slots[i+1];
		end
		psiq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.right_entry (right_e),
			.head_entry  (slots[0]),
			.left_flag   (left_f),
			.occupied    (CNT_W'(i) < cnt_q),
			.is_tail     (CNT_W'(i + 1) == cnt_q),
			.entry       (slots[i]),
			.flag        (flags[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			rd_active_q <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (rd_active_q) begin
				strobe_q <= 1'b1;
				rd_idx_q <= rd_idx_q + IDX_W'(1);
				if (rd_last) begin
					rd_active_q <= 1'b0;
				end
			end else if (accept) begin
				case (action)
					ACT_INSERT: begin
						strobe_q <= 1'b1;
						if (!full) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					ACT_READOUT: begin
						if (cnt_q == '0) begin
							strobe_q <= 1'b1;
						end else begin
							rd_active_q <= 1'b1;
							rd_idx_q    <= '0;
						end
					end
					ACT_CLEAR: begin
						strobe_q <= 1'b1;
						cnt_q    <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_active_q) begin
			status_q    <= ST_ENTRY;
			res_cnt_q   <= cnt_q;
			res_valid_q <= 1'b1;
			res_entry_q <= slots[0];
			last_q      <= rd_last;
		end else begin
			res_valid_q <= 1'b0;
			res_entry_q <= '0;
			last_q      <= 1'b1;
			case (action)
				ACT_INSERT: begin
					status_q  <= full ? ST_DROPPED : ST_INSERTED;
					res_cnt_q <= full ? cnt_q : cnt_q + CNT_W'(1);
				end
				default: begin
					status_q  <= ST_EMPTY;
					res_cnt_q <= '0;
				end
			endcase
		end
	end

	assign strobe             = strobe_q;
	assign status             = status_q;
	assign count              = COUNT_W'(res_cnt_q);
	assign entry_valid        = res_valid_q;
	assign entry_hybrid       = res_entry_q.hybrid;
	assign entry_new_fleet    = res_entry_q.new_fleet;
	assign entry_order_number = res_entry_q.order_number;
	assign last               = last_q;

endmodule
